### rtl/mmcs_pkg.sv
// Shared types and constants for the min/max contrast stretch block.
// No dependencies; used by mmcs_div_lane and min_max_contrast_stretch_8bit.
package mmcs_pkg;

  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned QUO_BITS    = 8;
  localparam int unsigned NUM_BITS    = SAMPLE_BITS + QUO_BITS;
  localparam int unsigned STEP_BITS   = $clog2(QUO_BITS);
  localparam int unsigned CNT_BITS    = 3;
  localparam int unsigned MIN_USED    = 3;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_CONVERT = 2'd2
  } op_e;

  // how a lane's result is formed once the divide is over
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ONE  = 2'd1,
    RES_FULL = 2'd2,
    RES_DIV  = 2'd3
  } res_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

### rtl/mmcs_div_lane.sv
// One bit-serial restoring divider lane: 8-bit quotient, one bit per cycle while ctrl_i.step is high.
// Depends on mmcs_pkg.
module mmcs_div_lane (
  input  logic                                clk_i,
  input  mmcs_pkg::div_ctrl_t                 ctrl_i,
  input  logic [mmcs_pkg::NUM_BITS-1:0]       num_i,
  input  logic [mmcs_pkg::SAMPLE_BITS-1:0]    den_i,
  output logic [mmcs_pkg::QUO_BITS-1:0]       quo_o
);

  logic [mmcs_pkg::SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [mmcs_pkg::SAMPLE_BITS-1:0] den_q, den_d;
  logic [mmcs_pkg::QUO_BITS-1:0]    low_q, low_d;
  logic [mmcs_pkg::QUO_BITS-1:0]    quo_q, quo_d;
  logic [mmcs_pkg::SAMPLE_BITS:0]   trial;
  logic [mmcs_pkg::SAMPLE_BITS:0]   diff;
  logic                             fits;

  assign trial = {rem_q, low_q[mmcs_pkg::QUO_BITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    low_d = low_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      // top part of the numerator is below the divisor, so it seeds the remainder
      rem_d = num_i[mmcs_pkg::NUM_BITS-1:mmcs_pkg::QUO_BITS];
      low_d = num_i[mmcs_pkg::QUO_BITS-1:0];
      den_d = den_i;
      quo_d = '0;
    end else if (ctrl_i.step) begin
      rem_d = fits ? diff[mmcs_pkg::SAMPLE_BITS-1:0] : trial[mmcs_pkg::SAMPLE_BITS-1:0];
      low_d = {low_q[mmcs_pkg::QUO_BITS-2:0], 1'b0};
      quo_d = {quo_q[mmcs_pkg::QUO_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

### rtl/min_max_contrast_stretch_8bit.sv
// Top level of the two-pass min/max contrast stretch, 16-bit samples to 8 bits.
// Depends on mmcs_pkg and mmcs_div_lane.
//
//   channel   signals                                    direction
//   input     in_valid_i / in_stall_o, op, samples, keep  into block
//   output    out_valid_o / out_stall_i, out_c0..out_c3   out of block
//   config    cfg_we_i, cfg_wdata_i (channel_count)       into block
//
// Clear and measure transactions are taken without stalling the input.
// A convert transaction holds the input through its capture, preparation,
// eight steps of the bit-serial dividers (one quotient bit a cycle, all lanes
// in parallel) and a load into the output register.
// The output register parts the sides: new transactions are taken while a
// result waits; a finished convert waits in DONE only if the register is full and stalled.
// Reset: extremes to empty (min all ones, max zero), channel_count to 3.
module min_max_contrast_stretch_8bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] sample_c0_i,
  input  logic [15:0] sample_c1_i,
  input  logic [15:0] sample_c2_i,
  input  logic [15:0] sample_c3_i,
  input  logic        keep_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_c0_o,
  output logic [7:0]  out_c1_o,
  output logic [7:0]  out_c2_o,
  output logic [7:0]  out_c3_o
);

  localparam int unsigned CH = mmcs_pkg::CHANNELS;
  localparam int unsigned SB = mmcs_pkg::SAMPLE_BITS;
  localparam int unsigned QB = mmcs_pkg::QUO_BITS;
  localparam int unsigned NB = mmcs_pkg::NUM_BITS;
  localparam int unsigned CB = mmcs_pkg::CNT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CB-1:0] cnt_q;            // channel_count register
  logic [CB-1:0] used;             // clamped channel count
  logic [CH-1:0] in_use;

  logic [SB-1:0] min_q [CH];
  logic [SB-1:0] max_q [CH];
  logic [SB-1:0] smp_q [CH];
  logic [SB-1:0] smp_in [CH];
  logic          keep_q;

  logic [mmcs_pkg::STEP_BITS-1:0] step_q, step_d;

  mmcs_pkg::div_ctrl_t div_ctrl;
  mmcs_pkg::res_e      kind_q [CH];
  mmcs_pkg::res_e      kind_d [CH];
  logic [NB-1:0]       num    [CH];
  logic [SB-1:0]       den    [CH];
  logic [QB-1:0]       quo    [CH];
  logic [SB-1:0]       delta  [CH];

  logic          out_valid_q;
  logic [7:0]    out_q [CH];
  logic [7:0]    res   [CH];
  logic          in_acc;
  logic          out_free;

  assign smp_in[0] = sample_c0_i;
  assign smp_in[1] = sample_c1_i;
  assign smp_in[2] = sample_c2_i;
  assign smp_in[3] = sample_c3_i;

  // clamp channel_count into [3, CHANNELS]
  always_comb begin
    used = cnt_q;
    if (cnt_q < CB'(mmcs_pkg::MIN_USED)) used = CB'(mmcs_pkg::MIN_USED);
    if (cnt_q > CB'(CH))                 used = CB'(CH);
  end

  for (genvar c = 0; c < CH; c++) begin : g_use
    assign in_use[c] = (CB'(c) < used);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CB'(mmcs_pkg::MIN_USED);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  // extremes: cleared by a clear transaction, folded by a kept measure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CH; c++) begin
        min_q[c] <= '1;
        max_q[c] <= '0;
      end
    end else if (in_acc) begin
      case (mmcs_pkg::op_e'(op_i))
        mmcs_pkg::OP_CLEAR: begin
          for (int c = 0; c < CH; c++) begin
            min_q[c] <= '1;
            max_q[c] <= '0;
          end
        end
        mmcs_pkg::OP_MEASURE: begin
          if (keep_i) begin
            for (int c = 0; c < CH; c++) begin
              if (in_use[c] && (smp_in[c] > max_q[c])) max_q[c] <= smp_in[c];
              if (in_use[c] && (smp_in[c] < min_q[c])) min_q[c] <= smp_in[c];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // capture of samples and keep on every accepted transaction, used by a convert
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int c = 0; c < CH; c++) smp_q[c] <= smp_in[c];
      keep_q <= keep_i;
    end
  end

  // lane preparation: decide special cases, form (v-min)*254 and max-min
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      delta[c] = smp_q[c] - min_q[c];
      den[c]   = max_q[c] - min_q[c];
      num[c]   = {delta[c], {QB{1'b0}}} - {{(QB-1){1'b0}}, delta[c], 1'b0};
      if (!keep_q || !in_use[c])                                kind_d[c] = mmcs_pkg::RES_ZERO;
      else if (max_q[c] <= min_q[c] || smp_q[c] <= min_q[c])   kind_d[c] = mmcs_pkg::RES_ONE;
      else if (smp_q[c] >= max_q[c])                            kind_d[c] = mmcs_pkg::RES_FULL;
      else                                                      kind_d[c] = mmcs_pkg::RES_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      for (int c = 0; c < CH; c++) kind_q[c] <= kind_d[c];
    end
  end

  assign div_ctrl.load = (state_q == ST_PREP);
  assign div_ctrl.step = (state_q == ST_DIV);

  for (genvar c = 0; c < CH; c++) begin : g_lane
    mmcs_div_lane u_div (
      .clk_i  (clk_i),
      .ctrl_i (div_ctrl),
      .num_i  (num[c]),
      .den_i  (den[c]),
      .quo_o  (quo[c])
    );
  end

  // quotient stays below 254 on the divide path, so 1 + q fits 8 bits
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      case (kind_q[c])
        mmcs_pkg::RES_ZERO: res[c] = 8'd0;
        mmcs_pkg::RES_ONE:  res[c] = 8'd1;
        mmcs_pkg::RES_FULL: res[c] = 8'd255;
        mmcs_pkg::RES_DIV:  res[c] = quo[c] + 8'd1;
        default:            res[c] = 8'd0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mmcs_pkg::op_e'(op_i) == mmcs_pkg::OP_CONVERT)) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == mmcs_pkg::STEP_BITS'(QB - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      for (int c = 0; c < CH; c++) out_q[c] <= res[c];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_c0_o    = out_q[0];
  assign out_c1_o    = out_q[1];
  assign out_c2_o    = out_q[2];
  assign out_c3_o    = out_q[3];

endmodule
